>>> design/bmwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwm_pkg
// Shared types, codes and constants for the banked memory window mapper.
// ----------------------------------------------------------------------------
package bmwm_pkg;

    // Default sizing of the top level
    localparam int DEF_MEM_BYTES     = 65536;
    localparam int DEF_MAP_ENTRIES   = 8;
    localparam int DEF_NUM_BANK_REGS = 4;

    // Field widths
    localparam int OP_W        = 2;
    localparam int OFFSET_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int MAP_LEN_W   = 4;
    localparam int SIZE_W      = 17;
    localparam int WCNT_W      = 3;
    localparam int MAP_SLOT_W  = 3;
    localparam int BANK_IDX_W  = 2;
    localparam int PROD_W      = BYTE_W + SIZE_W;
    localparam int ADDR_SUM_W  = PROD_W + 1;

    // Iterative divider
    localparam int DIV_W       = SIZE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Data constants
    localparam logic [BYTE_W-1:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] CLEAR_BYTE    = 8'h00;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] RST_MAP_TABLE    = '1;
    localparam logic [MAP_LEN_W-1:0]  RST_MAP_LENGTH   = '0;
    localparam logic [SIZE_W-1:0]     RST_BANK_BYTES   = 17'd1;
    localparam logic [WCNT_W-1:0]     RST_WIN_CNT      = 3'd1;
    localparam logic [SIZE_W-1:0]     RST_MEMORY_SIZE  = 17'd65536;

    typedef enum logic [OP_W-1:0] {
        OP_MAP_RD = 2'd0,
        OP_MAP_WR = 2'd1,
        OP_MEM_RD = 2'd2,
        OP_MEM_WR = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_TABLE    = 3'd0,
        CFG_MAP_LENGTH   = 3'd1,
        CFG_BANK_BYTES   = 3'd2,
        CFG_WIN_CNT      = 3'd3,
        CFG_MEMORY_SIZE  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_DIV,
        ST_MUL,
        ST_CHK,
        ST_RD,
        ST_OUT
    } back_state_t;

    // Effective configuration: zero sizes forced to one, limits applied
    typedef struct packed {
        logic [CFG_DATA_W-1:0] map_table;
        logic [MAP_LEN_W-1:0]  map_len;
        logic [SIZE_W-1:0]     bank_bytes;
        logic [WCNT_W-1:0]     win_cnt;
        logic [SIZE_W-1:0]     mem_size;
    } cfg_eff_t;

    // One classified access waiting for the back end
    typedef struct packed {
        op_t                   op;
        logic [OFFSET_W-1:0]   offset;
        logic [BYTE_W-1:0]     wdata;
        logic                  map_hit;
        logic [BANK_IDX_W-1:0] map_idx;
    } q_entry_t;

endpackage

>>> design/bmwm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwm_front
// Accepts bus accesses, resolves the mapper table lookup and queues them.
// ----------------------------------------------------------------------------
module bmwm_front #(
    parameter int NUM_BANK_REGS = bmwm_pkg::DEF_NUM_BANK_REGS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [bmwm_pkg::OP_W-1:0]        op,
    input  logic [bmwm_pkg::OFFSET_W-1:0]    offset,
    input  logic [bmwm_pkg::BYTE_W-1:0]      wdata,
    input  bmwm_pkg::cfg_eff_t               cfg,
    input  logic                             hold,
    output logic                             q_valid,
    input  logic                             q_pop,
    output bmwm_pkg::q_entry_t               q_data
);
    import bmwm_pkg::*;

    q_entry_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic                 accept;
    logic                 take;
    logic [BYTE_W-1:0]    raw_entry;
    q_entry_t             entry_in;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH)) || hold;
    assign accept  = push && !full;
    assign q_valid = (count_reg != '0);
    assign take    = q_pop && q_valid;
    assign q_data  = entries_reg[rd_ptr_reg];

    // Classify: map length is already clamped, so a covered offset is below eight
    always_comb
    begin
        raw_entry        = cfg.map_table[offset[MAP_SLOT_W-1:0]*BYTE_W +: BYTE_W];
        entry_in.op      = op_t'(op);
        entry_in.offset  = offset;
        entry_in.wdata   = wdata;
        entry_in.map_hit = (offset < OFFSET_W'(cfg.map_len))
                           && (32'(raw_entry) < NUM_BANK_REGS);
        entry_in.map_idx = raw_entry[BANK_IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entries_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (accept && !take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (take && !accept)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/bmwm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwm_div
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmwm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bmwm_pkg::DIV_W-1:0]   dvd_a,
    input  logic [bmwm_pkg::DIV_W-1:0]   dvd_b,
    input  logic [bmwm_pkg::DIV_W-1:0]   divisor,
    output logic                         busy,
    output logic [bmwm_pkg::DIV_W-1:0]   quot_a,
    output logic [bmwm_pkg::DIV_W-1:0]   rem_a,
    output logic [bmwm_pkg::DIV_W-1:0]   quot_b
);
    import bmwm_pkg::*;

    logic [DIV_W-1:0]     qa_reg, ra_reg, qb_reg, rb_reg, d_reg;
    logic [DIV_W-1:0]     qa_next, ra_next, qb_next, rb_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIV_W:0]       trial_a, trial_b, diff_a, diff_b;
    logic                 ge_a, ge_b;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        trial_a = {ra_reg, qa_reg[DIV_W-1]};
        trial_b = {rb_reg, qb_reg[DIV_W-1]};
        diff_a  = trial_a - {1'b0, d_reg};
        diff_b  = trial_b - {1'b0, d_reg};
        ge_a    = (trial_a >= {1'b0, d_reg});
        ge_b    = (trial_b >= {1'b0, d_reg});
        ra_next = ge_a ? diff_a[DIV_W-1:0] : trial_a[DIV_W-1:0];
        rb_next = ge_b ? diff_b[DIV_W-1:0] : trial_b[DIV_W-1:0];
        qa_next = {qa_reg[DIV_W-2:0], ge_a};
        qb_next = {qb_reg[DIV_W-2:0], ge_b};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qa_reg <= dvd_a;
            qb_reg <= dvd_b;
            ra_reg <= '0;
            rb_reg <= '0;
            d_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            qa_reg <= qa_next;
            qb_reg <= qb_next;
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign quot_a = qa_reg;
    assign rem_a  = ra_reg;
    assign quot_b = qb_reg;

endmodule

>>> design/bmwm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwm_back
// Carries out queued accesses: bank registers, window translation through
// the divider, backing memory with its reset clear, and the result register.
// ----------------------------------------------------------------------------
module bmwm_back #(
    parameter int MEM_BYTES     = bmwm_pkg::DEF_MEM_BYTES,
    parameter int NUM_BANK_REGS = bmwm_pkg::DEF_NUM_BANK_REGS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bmwm_pkg::cfg_eff_t            cfg,
    input  logic                          q_valid,
    input  bmwm_pkg::q_entry_t            q_data,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          empty,
    input  logic                          pop,
    output logic [bmwm_pkg::BYTE_W-1:0]   rdata
);
    import bmwm_pkg::*;

    localparam int AW  = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int BRW = (NUM_BANK_REGS > 1) ? $clog2(NUM_BANK_REGS) : 1;

    back_state_t            state_reg, state_next;
    q_entry_t               job_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [BYTE_W-1:0]      bank_regs_reg [NUM_BANK_REGS];
    logic [BYTE_W-1:0]      mem [MEM_BYTES];
    logic [BYTE_W-1:0]      mem_q_reg;
    logic                   win_ok_reg;
    logic [BYTE_W-1:0]      bank_m_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [BYTE_W-1:0]      res_reg;
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_data_reg;

    logic                   div_start, div_busy;
    logic [DIV_W-1:0]       quot_a, rem_a, quot_b, mask;
    logic [BANK_IDX_W-1:0]  bank_sel;
    logic [BYTE_W-1:0]      bank_rd, bank_masked;
    logic                   win_ok, is_read, q_is_map;
    logic [ADDR_SUM_W-1:0]  addr_sum;
    logic                   mem_hit;
    logic                   bank_we, mem_we, mem_re, out_load;
    logic [AW-1:0]          mem_addr;
    logic [BYTE_W-1:0]      mem_wdata;

    bmwm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dvd_a   ({1'b0, q_data.offset}),
        .dvd_b   (cfg.mem_size),
        .divisor (cfg.bank_bytes),
        .busy    (div_busy),
        .quot_a  (quot_a),
        .rem_a   (rem_a),
        .quot_b  (quot_b)
    );

    // Datapath decode
    always_comb
    begin
        is_read     = (job_reg.op == OP_MAP_RD) || (job_reg.op == OP_MEM_RD);
        q_is_map    = (q_data.op == OP_MAP_RD) || (q_data.op == OP_MAP_WR);
        bank_sel    = (state_reg == ST_MAP) ? job_reg.map_idx : quot_a[BANK_IDX_W-1:0];
        bank_rd     = bank_regs_reg[bank_sel[BRW-1:0]];
        win_ok      = (quot_a < DIV_W'(cfg.win_cnt))
                      && (32'(quot_a) < NUM_BANK_REGS);
        mask        = quot_b - 1'b1;
        // A bank count of zero or one leaves the bank register unmasked
        bank_masked = (quot_b > DIV_W'(1)) ? (bank_rd & mask[BYTE_W-1:0]) : bank_rd;
        addr_sum    = ADDR_SUM_W'(prod_reg) + ADDR_SUM_W'(rem_a);
        mem_hit     = win_ok_reg && (addr_sum < ADDR_SUM_W'(cfg.mem_size));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_is_map ? ST_MAP : ST_DIV;
                end
            end
            ST_MAP:
            begin
                state_next = is_read ? ST_OUT : ST_IDLE;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (is_read)
                begin
                    state_next = mem_hit ? ST_RD : ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        bank_we   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        out_load  = 1'b0;
        clearing  = 1'b0;
        mem_addr  = clr_addr_reg;
        mem_wdata = CLEAR_BYTE;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                mem_we   = 1'b1;
            end
            ST_IDLE:
            begin
                q_pop     = q_valid;
                div_start = q_valid && !q_is_map;
            end
            ST_MAP:
            begin
                bank_we = !is_read && job_reg.map_hit;
            end
            ST_CHK:
            begin
                mem_addr  = addr_sum[AW-1:0];
                mem_wdata = job_reg.wdata;
                mem_we    = !is_read && mem_hit;
                mem_re    = is_read && mem_hit;
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || pop;
            end
            default:
            begin
            end
        endcase
    end

    // Backing memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    // Job and translation payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if ((state_reg == ST_DIV) && !div_busy)
        begin
            win_ok_reg <= win_ok;
            bank_m_reg <= bank_masked;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(bank_m_reg) * PROD_W'(cfg.bank_bytes);
        end
        case (state_reg)
            ST_MAP:  res_reg <= job_reg.map_hit ? bank_rd : UNMAPPED_BYTE;
            ST_CHK:  res_reg <= UNMAPPED_BYTE;
            ST_RD:   res_reg <= mem_q_reg;
            default: res_reg <= res_reg;
        endcase
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // Control state and bank registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BANK_REGS; i++)
            begin
                bank_regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (bank_we)
            begin
                bank_regs_reg[bank_sel[BRW-1:0]] <= job_reg.wdata;
            end
        end
    end

    assign empty = !out_valid_reg;
    assign rdata = out_data_reg;

endmodule

>>> design/banked_memory_window_mapper_top.sv
`timescale 1ns / 1ps
// A banked memory access runs through the 17-step divider; the back end
//   carries out one queued access at a time.
// Reset: the backing memory is cleared one byte a cycle, during which full
//   stays high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// banked_memory_window_mapper_top
// Bank switching memory mapper: a mapper port that selects bank registers
// through a table, and a windowed view of a banked backing memory.
// ----------------------------------------------------------------------------
module banked_memory_window_mapper_top #(
    parameter int MEM_BYTES     = bmwm_pkg::DEF_MEM_BYTES,
    parameter int MAP_ENTRIES   = bmwm_pkg::DEF_MAP_ENTRIES,
    parameter int NUM_BANK_REGS = bmwm_pkg::DEF_NUM_BANK_REGS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Access channel
    input  logic                             push,
    output logic                             full,
    input  logic [bmwm_pkg::OP_W-1:0]        op,
    input  logic [bmwm_pkg::OFFSET_W-1:0]    offset,
    input  logic [bmwm_pkg::BYTE_W-1:0]      wdata,
    // Result channel
    output logic                             empty,
    input  logic                             pop,
    output logic [bmwm_pkg::BYTE_W-1:0]      rdata,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmwm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bmwm_pkg::*;

    logic [CFG_DATA_W-1:0] map_table_reg;
    logic [MAP_LEN_W-1:0]  map_length_reg;
    logic [SIZE_W-1:0]     bank_bytes_reg;
    logic [WCNT_W-1:0]     win_cnt_reg;
    logic [SIZE_W-1:0]     memory_size_reg;
    cfg_eff_t              cfg_eff;
    logic                  q_valid, q_pop, clearing;
    q_entry_t              q_data;

    // Always writable; software must write registers only while idle, not enforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_table_reg    <= RST_MAP_TABLE;
            map_length_reg   <= RST_MAP_LENGTH;
            bank_bytes_reg   <= RST_BANK_BYTES;
            win_cnt_reg      <= RST_WIN_CNT;
            memory_size_reg  <= RST_MEMORY_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAP_TABLE:    map_table_reg    <= cfg_data;
                CFG_MAP_LENGTH:   map_length_reg   <= cfg_data[MAP_LEN_W-1:0];
                CFG_BANK_BYTES:   bank_bytes_reg   <= cfg_data[SIZE_W-1:0];
                CFG_WIN_CNT:      win_cnt_reg      <= cfg_data[WCNT_W-1:0];
                CFG_MEMORY_SIZE:  memory_size_reg  <= cfg_data[SIZE_W-1:0];
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Effective settings: zero bank size and window count act as one, the map
    // length stops at the table size, the memory size at the physical memory
    always_comb
    begin
        cfg_eff.map_table  = map_table_reg;
        cfg_eff.map_len    = (32'(map_length_reg) > MAP_ENTRIES)
                             ? MAP_LEN_W'(MAP_ENTRIES) : map_length_reg;
        cfg_eff.bank_bytes = (bank_bytes_reg == '0) ? SIZE_W'(1) : bank_bytes_reg;
        cfg_eff.win_cnt    = (win_cnt_reg == '0) ? WCNT_W'(1) : win_cnt_reg;
        cfg_eff.mem_size   = (32'(memory_size_reg) > MEM_BYTES)
                             ? SIZE_W'(MEM_BYTES) : memory_size_reg;
    end

    // Front: accept and classify, hold off while the memory is being cleared
    bmwm_front #(
        .NUM_BANK_REGS (NUM_BANK_REGS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .op      (op),
        .offset  (offset),
        .wdata   (wdata),
        .cfg     (cfg_eff),
        .hold    (clearing),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    // Back: execute one transaction at a time, park results in the output register
    bmwm_back #(
        .MEM_BYTES     (MEM_BYTES),
        .NUM_BANK_REGS (NUM_BANK_REGS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_eff),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .clearing (clearing),
        .empty    (empty),
        .pop      (pop),
        .rdata    (rdata)
    );

endmodule

>>> dv/bmwm_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmwm_access_checker
// Watches the access, result and register channels of the banked memory
// window mapper. Keeps its own copy of the registers, bank registers and
// backing memory, works out the byte each read returns, and compares it
// with the byte popped from the block.
// ----------------------------------------------------------------------------
module bmwm_access_checker
    import bmwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [OP_W-1:0]       op,
    input  logic [OFFSET_W-1:0]   offset,
    input  logic [BYTE_W-1:0]     wdata,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [BYTE_W-1:0]     rdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    logic [CFG_DATA_W-1:0] map_tbl;
    logic [MAP_LEN_W-1:0]  map_len;
    logic [SIZE_W-1:0]     bank_bytes;
    logic [WCNT_W-1:0]     win_count;
    logic [SIZE_W-1:0]     mem_bytes;
    logic [BYTE_W-1:0]     bank_reg [DEF_NUM_BANK_REGS];
    logic [BYTE_W-1:0]     mem_img [DEF_MEM_BYTES];
    logic [BYTE_W-1:0]     expected_rdata [$];

    // Resolve a mapper port offset to a bank register index.
    function automatic bit mapper_slot(input logic [OFFSET_W-1:0] off,
                                       output logic [BANK_IDX_W-1:0] idx);
        logic [MAP_LEN_W-1:0] len;
        logic [BYTE_W-1:0]    entry;
        idx = '0;
        len = (map_len > DEF_MAP_ENTRIES) ? MAP_LEN_W'(DEF_MAP_ENTRIES) : map_len;
        if (off >= len)
            return 1'b0;
        entry = map_tbl[off[MAP_SLOT_W-1:0]*BYTE_W +: BYTE_W];
        // negative entries land above the register count as unsigned
        if (entry >= DEF_NUM_BANK_REGS)
            return 1'b0;
        idx = entry[BANK_IDX_W-1:0];
        return 1'b1;
    endfunction

    // Resolve a banked memory offset to a physical byte address.
    function automatic bit window_address(input logic [OFFSET_W-1:0] off,
                                          output int unsigned phys);
        longint unsigned bsz, wcnt, msz, banks, mask, win, bank, addr;
        phys = 0;
        bsz  = (bank_bytes == 0) ? 1 : bank_bytes;
        wcnt = (win_count == 0) ? 1 : win_count;
        msz  = (mem_bytes > DEF_MEM_BYTES) ? DEF_MEM_BYTES : mem_bytes;
        banks = msz / bsz;
        mask  = (banks != 0) ? banks - 1 : 0;
        win   = off / bsz;
        if (win >= wcnt || win >= DEF_NUM_BANK_REGS)
            return 1'b0;
        bank = bank_reg[win];
        if (mask != 0)
            bank = bank & mask;
        addr = bank * bsz + off % bsz;
        if (addr >= msz)
            return 1'b0;
        phys = int'(addr);
        return 1'b1;
    endfunction

    task automatic predict_access(input op_t kind, input logic [OFFSET_W-1:0] off,
                                  input logic [BYTE_W-1:0] wd);
        logic [BANK_IDX_W-1:0] idx;
        int unsigned           phys;
        case (kind)
            OP_MAP_RD:
                if (mapper_slot(off, idx))
                    expected_rdata.push_back(bank_reg[idx]);
                else
                    expected_rdata.push_back(UNMAPPED_BYTE);
            OP_MAP_WR:
                if (mapper_slot(off, idx))
                    bank_reg[idx] = wd;
            OP_MEM_RD:
                if (window_address(off, phys))
                    expected_rdata.push_back(mem_img[phys]);
                else
                    expected_rdata.push_back(UNMAPPED_BYTE);
            default:
                if (window_address(off, phys))
                    mem_img[phys] = wd;
        endcase
    endtask

    task automatic check_rdata(input logic [BYTE_W-1:0] got);
        logic [BYTE_W-1:0] want;
        if (expected_rdata.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] rdata %02h popped with no read outstanding", $realtime, got);
        end
        else
        begin
            want = expected_rdata.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] rdata mismatch: expected %02h, got %02h",
                             $realtime, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_tbl    = RST_MAP_TABLE;
            map_len    = RST_MAP_LENGTH;
            bank_bytes = RST_BANK_BYTES;
            win_count  = RST_WIN_CNT;
            mem_bytes  = RST_MEMORY_SIZE;
            foreach (bank_reg[i])
                bank_reg[i] = CLEAR_BYTE;
            foreach (mem_img[a])
                mem_img[a] = CLEAR_BYTE;
            expected_rdata.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
                check_rdata(rdata);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MAP_TABLE:    map_tbl    = cfg_data;
                    CFG_MAP_LENGTH:   map_len    = cfg_data[MAP_LEN_W-1:0];
                    CFG_BANK_BYTES:   bank_bytes = cfg_data[SIZE_W-1:0];
                    CFG_WIN_CNT:      win_count  = cfg_data[WCNT_W-1:0];
                    CFG_MEMORY_SIZE:  mem_bytes  = cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_access(op_t'(op), offset, wdata);
            pending = expected_rdata.size();
        end
    end

endmodule

>>> dv/tb_banked_memory_window_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_banked_memory_window_mapper_top
// Drives bus accesses and register writes into the banked memory window
// mapper, with random gaps on both queue sides, and lets the access checker
// predict and compare every byte read back.
// ----------------------------------------------------------------------------
module tb_banked_memory_window_mapper_top;
    import bmwm_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;     // long receiver stall
    localparam int SETTLE_CYCLES   = 100;     // covers the writes still queued
    localparam int WATCHDOG_LIMIT  = 250000;  // clearing pass plus margin
    localparam int HOT_SLOTS       = 16;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic [OP_W-1:0]       op        = '0;
    logic [OFFSET_W-1:0]   offset    = '0;
    logic [BYTE_W-1:0]     wdata     = '0;
    logic                  pop       = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  full;
    logic                  empty;
    logic [BYTE_W-1:0]     rdata;
    logic                  cfg_ready;

    int fail_count;
    int pending;

    // Shared between the sender and the receiver process
    bit calm     = 1'b0;   // no idling in the last phase
    bit hold_req = 1'b0;   // ask the receiver for one long stall

    // Shape of the current window layout, used to aim memory offsets
    int unsigned         cur_span;
    logic [OFFSET_W-1:0] hot_offs [HOT_SLOTS];
    int                  idle_cycles = 0;

    always #2 clk = ~clk;

    banked_memory_window_mapper_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .offset    (offset),
        .wdata     (wdata),
        .empty     (empty),
        .pop       (pop),
        .rdata     (rdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmwm_access_checker u_access_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .offset     (offset),
        .wdata      (wdata),
        .empty      (empty),
        .pop        (pop),
        .rdata      (rdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Eight table entries, mostly valid bank register numbers, the rest any
    // byte so negative and too-large entries show up.
    function automatic logic [CFG_DATA_W-1:0] random_table();
        logic [CFG_DATA_W-1:0] tbl;
        for (int i = 0; i < DEF_MAP_ENTRIES; i++)
            tbl[i*BYTE_W +: BYTE_W] = ($urandom_range(0, 3) == 0)
                ? BYTE_W'($urandom()) : BYTE_W'($urandom_range(0, DEF_NUM_BANK_REGS-1));
        return tbl;
    endfunction

    // Present one register write and hold until the channel takes it.
    // Valid is left high; the caller drops it after the last write.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all five registers back to back, then refresh the offset pool
    // so memory traffic lands inside the new windows and reuses addresses.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] tbl,
                                input logic [MAP_LEN_W-1:0] len,
                                input logic [SIZE_W-1:0] bsz,
                                input logic [WCNT_W-1:0] wcnt,
                                input logic [SIZE_W-1:0] msz);
        int unsigned eff_bsz;
        int unsigned eff_wcnt;
        write_reg(CFG_MAP_TABLE,    tbl);
        write_reg(CFG_MAP_LENGTH,   CFG_DATA_W'(len));
        write_reg(CFG_BANK_BYTES,   CFG_DATA_W'(bsz));
        write_reg(CFG_WIN_CNT,      CFG_DATA_W'(wcnt));
        write_reg(CFG_MEMORY_SIZE,  CFG_DATA_W'(msz));
        cfg_valid <= 1'b0;
        eff_bsz  = (bsz == 0) ? 1 : bsz;
        eff_wcnt = (wcnt == 0) ? 1 : wcnt;
        cur_span = eff_bsz * eff_wcnt;
        if (cur_span > DEF_MEM_BYTES)
            cur_span = DEF_MEM_BYTES;
        foreach (hot_offs[i])
            hot_offs[i] = OFFSET_W'($urandom_range(0, cur_span - 1));
    endtask

    // Offer one access; an idle burst may come first. Push stays high after
    // the transaction so back-to-back accesses need no extra step.
    task automatic send_access(input op_t kind, input logic [OFFSET_W-1:0] off,
                               input logic [BYTE_W-1:0] wd);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push   <= 1'b1;
        op     <= kind;
        offset <= off;
        wdata  <= wd;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic random_access();
        op_t                 kind;
        logic [OFFSET_W-1:0] off;
        int                  r;
        r = $urandom_range(0, 99);
        kind = (r < 20) ? OP_MAP_WR : (r < 35) ? OP_MAP_RD :
               (r < 65) ? OP_MEM_WR : OP_MEM_RD;
        r = $urandom_range(0, 99);
        if (kind == OP_MAP_RD || kind == OP_MAP_WR)
            // mostly the table slots and just past them, sometimes anything
            off = (r < 80) ? OFFSET_W'($urandom_range(0, 9)) : OFFSET_W'($urandom());
        else if (r < 55)
            off = hot_offs[$urandom_range(0, HOT_SLOTS-1)];
        else if (r < 85)
            off = OFFSET_W'($urandom_range(0, cur_span - 1));
        else if (r < 90 && cur_span < DEF_MEM_BYTES)
            off = OFFSET_W'(cur_span);   // first offset past the last window
        else
            off = OFFSET_W'($urandom());
        send_access(kind, off, BYTE_W'($urandom()));
    endtask

    // Drop push, wait out every outstanding read, then give the writes still
    // queued behind it time to land before the registers may change. Sample
    // pending on the falling edge, away from the checker's update.
    task automatic drain();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: pop is a level; gaps come in random bursts, plus one long
    // stall on request so the block backs up and holds off the sender.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            else if (hold_left == 0 && !calm && $urandom_range(0, 11) == 0)
                hold_left = $urandom_range(1, 18);
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: count cycles without any transaction on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_banked_memory_window_mapper_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] dir_tbl;
        logic [SIZE_W-1:0]     bsz;
        logic [SIZE_W-1:0]     msz;
        int                    r;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Table: slots 0-3 name bank registers 0-3; slot 4 is negative,
        // slot 5 one past the register count, slots 6 and 7 all ones and 0x7F.
        dir_tbl = 64'h7FFF_0480_0302_0100;

        // Four windows of 16 bytes over 64 bytes: four banks, mask 3.
        // Registers go in while the clearing pass still holds off accesses.
        program_regs(dir_tbl, 4'd8, 17'd16, 3'd4, 17'd64);
        send_access(OP_MAP_WR, 16'h0000, 8'h00);
        send_access(OP_MAP_WR, 16'h0001, 8'hFF);   // bank 1 masked down to 3
        send_access(OP_MAP_WR, 16'h0002, 8'h01);
        send_access(OP_MAP_WR, 16'h0003, 8'h02);
        send_access(OP_MAP_WR, 16'h0004, 8'h55);   // negative entry, dropped
        send_access(OP_MAP_WR, 16'h0008, 8'h66);   // past the table, dropped
        send_access(OP_MAP_RD, 16'h0001, 8'h00);
        send_access(OP_MAP_RD, 16'h0003, 8'h00);
        send_access(OP_MAP_RD, 16'h0005, 8'h00);   // entry too large
        send_access(OP_MAP_RD, 16'hFFFF, 8'h00);
        send_access(OP_MEM_WR, 16'h0005, 8'hA5);
        send_access(OP_MEM_WR, 16'h001F, 8'h3C);
        send_access(OP_MEM_WR, 16'h003F, 8'hFF);
        send_access(OP_MEM_WR, 16'h0040, 8'h77);   // window 4, dropped
        send_access(OP_MEM_RD, 16'h0005, 8'h00);
        send_access(OP_MEM_RD, 16'h001F, 8'h00);
        send_access(OP_MEM_RD, 16'h003F, 8'h00);
        send_access(OP_MEM_RD, 16'hFFFF, 8'h00);
        send_access(OP_MEM_RD, 16'h0040, 8'h00);
        drain();

        // One bank only: mask is zero, bank register 1 (0xFF) is used as is
        // and lands far outside memory.
        program_regs(dir_tbl, 4'd8, 17'd64, 3'd2, 17'd64);
        send_access(OP_MEM_RD, 16'h0005, 8'h00);
        send_access(OP_MEM_WR, 16'h0045, 8'h99);
        send_access(OP_MEM_RD, 16'h0045, 8'h00);
        drain();

        // Zero sizes and zero memory: every memory access is unmapped.
        program_regs(dir_tbl, 4'd0, 17'd0, 3'd0, 17'd0);
        send_access(OP_MEM_WR, 16'h0000, 8'h11);
        send_access(OP_MEM_RD, 16'h0000, 8'h00);
        send_access(OP_MAP_RD, 16'h0000, 8'h00);   // empty table
        drain();

        // Layout extremes, each with random traffic. Draining between them
        // also makes the sender wait for every outstanding read.
        program_regs(random_table(), 4'd8, 17'd65536, 3'd4, 17'd65536);
        repeat (100) random_access();
        drain();
        program_regs(random_table(), 4'd0, 17'd1, 3'd4, 17'd65536);
        repeat (100) random_access();
        drain();
        program_regs(random_table(), 4'd8, 17'd0, 3'd0, 17'd65536);
        repeat (100) random_access();
        drain();
        program_regs(random_table(), 4'd5, 17'd4096, 3'd4, 17'd16384);
        repeat (100) random_access();
        drain();
        program_regs(random_table(), 4'd8, 17'd100, 3'd3, 17'd1000);
        repeat (100) random_access();
        drain();
        program_regs(random_table(), 4'd7, 17'd256, 3'd4, 17'd65535);
        repeat (100) random_access();
        drain();

        // Random layouts; one phase carries the long receiver stall and the
        // last runs with no idling on either side.
        for (int p = 0; p < 8; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                bsz = SIZE_W'($urandom_range(1, 64));
            else if (r < 60)
                bsz = SIZE_W'($urandom_range(65, 4096));
            else if (r < 70)
                bsz = '0;
            else if (r < 85)
                bsz = SIZE_W'(1) << $urandom_range(0, 16);
            else
                bsz = SIZE_W'($urandom_range(0, DEF_MEM_BYTES));
            r = $urandom_range(0, 99);
            if (r < 20)
                msz = SIZE_W'(DEF_MEM_BYTES);
            else if (r < 30)
                msz = '0;
            else if (r < 70)
                msz = SIZE_W'((bsz * $urandom_range(1, 8) > DEF_MEM_BYTES)
                              ? DEF_MEM_BYTES : bsz * $urandom_range(1, 8));
            else
                msz = SIZE_W'($urandom_range(0, DEF_MEM_BYTES));
            if (p == 7)
                calm = 1'b1;
            program_regs(random_table(), MAP_LEN_W'($urandom_range(0, DEF_MAP_ENTRIES)),
                         bsz, WCNT_W'($urandom_range(0, DEF_NUM_BANK_REGS)), msz);
            if (p == 2)
                hold_req <= 1'b1;
            repeat (103) random_access();
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_banked_memory_window_mapper_top OK");
        else
            $display("tb_banked_memory_window_mapper_top NOT OK");
        $finish;
    end

endmodule

>>> sim.f
design/bmwm_pkg.sv
design/bmwm_front.sv
design/bmwm_div.sv
design/bmwm_back.sv
design/banked_memory_window_mapper_top.sv
dv/bmwm_access_checker.sv
dv/tb_banked_memory_window_mapper_top.sv
